/* rtl/core/jads_pkg.sv */
package jads_pkg;

   // Result width and the full-scale codes of the signed axis value
   localparam int AXIS_BITS = 16;
   localparam logic [AXIS_BITS-1:0] POS_FULL = 16'h7FFF;
   localparam logic [AXIS_BITS-1:0] NEG_FULL = 16'h8000;

   // distance * 32768 is a plain shift; distance * 32767 is that shift minus distance
   localparam int POS_SCALE_SHIFT = 15;

   // Jobs buffered between the classifier and the divider
   localparam int QUEUE_DEPTH = 4;

   // Calibration reset values before masking to the sample width
   localparam int CAL_CENTER_DEFAULT = 2048;
   localparam int CAL_MAX_DEFAULT = 4095;

   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CAL_MIN     = 3'd0,
      CSR_CAL_CENTER  = 3'd1,
      CSR_CAL_MAX     = 3'd2,
      CSR_DEAD_BAND   = 3'd3,
      CSR_INVERT_AXIS = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      CLS_ZERO,
      CLS_POS,
      CLS_NEG,
      CLS_FULL_POS,
      CLS_FULL_NEG
   } item_class_type;

   typedef struct packed {
      item_class_type cls;
      logic           invert;
   } job_ctl_type;

endpackage

/* rtl/core/jads_front.sv */
module jads_front #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [SAMPLE_BITS-1:0]   sample,
   input  logic [SAMPLE_BITS-1:0]   cal_min,
   input  logic [SAMPLE_BITS-1:0]   cal_center,
   input  logic [SAMPLE_BITS-1:0]   cal_max,
   input  logic [SAMPLE_BITS-1:0]   dead_band,
   input  logic                     invert_axis,
   output logic [1:0]               busy_count,
   output logic                     push,
   output jads_pkg::job_ctl_type    push_ctl,
   output logic [SAMPLE_BITS-1:0]   push_dist,
   output logic [SAMPLE_BITS-1:0]   push_span
);
   import jads_pkg::*;

   localparam int WB = SAMPLE_BITS + 2;

   // Stage one: band edges and which side of the band the sample sits on
   logic [SAMPLE_BITS:0]    hi_edge_in;
   logic signed [WB-1:0]    lo_edge_in;
   logic                    above_in;
   logic                    below_in;

   logic                    f1_valid_ff;
   logic [SAMPLE_BITS-1:0]  f1_sample_ff;
   logic [SAMPLE_BITS:0]    f1_hi_ff;
   logic signed [WB-1:0]    f1_lo_ff;
   logic                    f1_above_ff;
   logic                    f1_below_ff;
   logic [SAMPLE_BITS-1:0]  f1_min_ff;
   logic [SAMPLE_BITS-1:0]  f1_max_ff;
   logic                    f1_invert_ff;

   always_comb begin
      hi_edge_in = {1'b0, cal_center} + {1'b0, dead_band};
      lo_edge_in = $signed({2'b00, cal_center}) - $signed({2'b00, dead_band});
      above_in   = {1'b0, sample} > hi_edge_in;
      below_in   = $signed({2'b00, sample}) < lo_edge_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f1_sample_ff <= sample;
         f1_hi_ff     <= hi_edge_in;
         f1_lo_ff     <= lo_edge_in;
         f1_above_ff  <= above_in;
         f1_below_ff  <= below_in;
         f1_min_ff    <= cal_min;
         f1_max_ff    <= cal_max;
         f1_invert_ff <= invert_axis;
      end
   end

   // Stage two: span, distance from the band edge, clamp
   logic signed [WB-1:0]    s_ext;
   logic signed [WB-1:0]    hi_ext;
   logic signed [WB-1:0]    span_pos;
   logic signed [WB-1:0]    span_neg;
   logic signed [WB-1:0]    d_pos;
   logic signed [WB-1:0]    d_neg;
   logic signed [WB-1:0]    span_sel;
   logic signed [WB-1:0]    d_sel;
   logic signed [WB-1:0]    d_clamp;
   job_ctl_type             ctl_in;

   always_comb begin
      s_ext    = $signed({2'b00, f1_sample_ff});
      hi_ext   = $signed({1'b0, f1_hi_ff});
      span_pos = $signed({2'b00, f1_max_ff}) - hi_ext;
      span_neg = f1_lo_ff - $signed({2'b00, f1_min_ff});
      d_pos    = s_ext - hi_ext;
      d_neg    = f1_lo_ff - s_ext;
      ctl_in.invert = f1_invert_ff;
      priority if (f1_above_ff) begin
         span_sel = span_pos;
         d_sel    = d_pos;
         ctl_in.cls = (span_pos[WB-1] || span_pos == '0) ? CLS_FULL_POS : CLS_POS;
      end else if (f1_below_ff) begin
         span_sel = span_neg;
         d_sel    = d_neg;
         ctl_in.cls = (span_neg[WB-1] || span_neg == '0) ? CLS_FULL_NEG : CLS_NEG;
      end else begin
         span_sel = span_pos;
         d_sel    = d_pos;
         ctl_in.cls = CLS_ZERO;
      end
      d_clamp = (d_sel > span_sel) ? span_sel : d_sel;
   end

   logic                    f2_valid_ff;
   job_ctl_type             f2_ctl_ff;
   logic [SAMPLE_BITS-1:0]  f2_dist_ff;
   logic [SAMPLE_BITS-1:0]  f2_span_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_valid_ff <= 1'b0;
      end else begin
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (f1_valid_ff) begin
         f2_ctl_ff  <= ctl_in;
         f2_dist_ff <= d_clamp[SAMPLE_BITS-1:0];
         f2_span_ff <= span_sel[SAMPLE_BITS-1:0];
      end
   end

   assign busy_count = {1'b0, f1_valid_ff} + {1'b0, f2_valid_ff};
   assign push       = f2_valid_ff;
   assign push_ctl   = f2_ctl_ff;
   assign push_dist  = f2_dist_ff;
   assign push_span  = f2_span_ff;

endmodule

/* rtl/core/jads_queue.sv */
module jads_queue #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST = PTR_BITS'(DEPTH - 1);

   logic [WIDTH-1:0]      slot_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff;
   logic [PTR_BITS-1:0]   wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff;
   logic [PTR_BITS-1:0]   rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + COUNT_BITS'(1);
         2'b01:   count_in = count_ff - COUNT_BITS'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = slot_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
   assign count    = count_ff;

endmodule

/* rtl/core/jads_back.sv */
module jads_back #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              job_empty,
   input  jads_pkg::job_ctl_type             job_ctl,
   input  logic [SAMPLE_BITS-1:0]            job_dist,
   input  logic [SAMPLE_BITS-1:0]            job_span,
   output logic                              job_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [jads_pkg::AXIS_BITS-1:0]    rsp_value
);
   import jads_pkg::*;

   localparam int QB       = AXIS_BITS;
   localparam int NUM_BITS = SAMPLE_BITS + POS_SCALE_SHIFT;

   logic                    adv;
   logic [NUM_BITS-1:0]     num_in;

   logic [QB:0]             valid_ff;
   logic [SAMPLE_BITS-1:0]  rem_ff  [QB+1];
   logic [QB-1:0]           low_ff  [QB+1];
   logic [QB-1:0]           quo_ff  [QB+1];
   logic [SAMPLE_BITS-1:0]  span_ff [QB+1];
   job_ctl_type             ctl_ff  [QB+1];

   logic [SAMPLE_BITS:0]    trial   [1:QB];
   logic [SAMPLE_BITS:0]    diff    [1:QB];
   logic                    fit     [1:QB];

   logic                    rsp_valid_ff;
   logic [AXIS_BITS-1:0]    rsp_value_ff;
   logic [AXIS_BITS-1:0]    value_in;
   logic [QB-1:0]           quo;
   logic [QB-1:0]           neg_quo;

   // Hold the whole back pipeline while a finished beat waits downstream
   assign adv     = !rsp_valid_ff || !rsp_stall;
   assign job_pop = adv && !job_empty;

   // Numerator: distance * 32767 on the positive side, distance * 32768 below
   always_comb begin
      num_in = NUM_BITS'(job_dist) << POS_SCALE_SHIFT;
      if (job_ctl.cls == CLS_POS) begin
         num_in = num_in - NUM_BITS'(job_dist);
      end
   end

   // One quotient bit per stage, restoring compare and subtract
   always_comb begin
      for (int k = 1; k <= QB; k++) begin
         trial[k] = {rem_ff[k-1], low_ff[k-1][QB-1]};
         diff[k]  = trial[k] - {1'b0, span_ff[k-1]};
         fit[k]   = trial[k] >= {1'b0, span_ff[k-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[QB-1:0], job_pop};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0]  <= SAMPLE_BITS'(num_in[NUM_BITS-1:QB]);
         low_ff[0]  <= num_in[QB-1:0];
         quo_ff[0]  <= '0;
         span_ff[0] <= job_span;
         ctl_ff[0]  <= job_ctl;
         for (int k = 1; k <= QB; k++) begin
            rem_ff[k]  <= fit[k] ? diff[k][SAMPLE_BITS-1:0] : trial[k][SAMPLE_BITS-1:0];
            low_ff[k]  <= {low_ff[k-1][QB-2:0], 1'b0};
            quo_ff[k]  <= {quo_ff[k-1][QB-2:0], fit[k]};
            span_ff[k] <= span_ff[k-1];
            ctl_ff[k]  <= ctl_ff[k-1];
         end
      end
   end

   // Sign, invert and saturate
   always_comb begin
      quo     = quo_ff[QB];
      neg_quo = ~quo + QB'(1);
      unique case (ctl_ff[QB].cls)
         CLS_ZERO:     value_in = '0;
         CLS_FULL_POS: value_in = POS_FULL;
         CLS_FULL_NEG: value_in = NEG_FULL;
         CLS_POS:      value_in = ctl_ff[QB].invert ? neg_quo : quo;
         CLS_NEG: begin
            if (ctl_ff[QB].invert) begin
               value_in = (quo == NEG_FULL) ? POS_FULL : quo;
            end else begin
               value_in = neg_quo;
            end
         end
         default:      value_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= valid_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_value_ff <= value_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

endmodule

/* rtl/core/joystick_axis_deadzone_scaler_unit.sv */
// Joystick axis scaler: maps one raw converter sample per beat to a signed
// 16-bit axis position using calibrated min, center, max and a dead band.
//
// Channels: req_ (valid/stall, payload req_raw_sample) in, rsp_ (valid/stall,
// payload rsp_axis_value) out. A beat moves when valid is high and stall low.
// Calibration is written via csr_write_enable/csr_index/csr_wdata; the user
// writes only while no sample is in flight (unenforced); unknown indexes drop.
//
// Throughput: one sample per cycle while req_stall is low. A sample passes
// through two classify stages, a slot in the job queue, the numerator stage,
// sixteen divider stages (one quotient bit each) and the output register.
//
// A stalled result holds the output register and the divider pipeline; the
// classifier keeps running into a four-entry job queue, and req_stall rises
// once the queue plus the classify stages could no longer absorb another beat.
//
// Reset empties the queue and both pipelines and loads the default
// calibration (center at mid-scale, max at full scale, no band, no invert).
module joystick_axis_deadzone_scaler_unit #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [SAMPLE_BITS-1:0]                req_raw_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [jads_pkg::AXIS_BITS-1:0]        rsp_axis_value,
   input  logic                                  csr_write_enable,
   input  logic [jads_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [SAMPLE_BITS-1:0]                csr_wdata
);
   import jads_pkg::*;

   localparam int JOB_BITS   = $bits(job_ctl_type) + 2 * SAMPLE_BITS;
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [SAMPLE_BITS-1:0] CENTER_RESET = SAMPLE_BITS'(CAL_CENTER_DEFAULT);
   localparam logic [SAMPLE_BITS-1:0] MAX_RESET    = SAMPLE_BITS'(CAL_MAX_DEFAULT);

   logic [SAMPLE_BITS-1:0] cal_min_ff;
   logic [SAMPLE_BITS-1:0] cal_center_ff;
   logic [SAMPLE_BITS-1:0] cal_max_ff;
   logic [SAMPLE_BITS-1:0] dead_band_ff;
   logic                   invert_axis_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_min_ff     <= '0;
         cal_center_ff  <= CENTER_RESET;
         cal_max_ff     <= MAX_RESET;
         dead_band_ff   <= '0;
         invert_axis_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_CAL_MIN:     cal_min_ff     <= csr_wdata;
            CSR_CAL_CENTER:  cal_center_ff  <= csr_wdata;
            CSR_CAL_MAX:     cal_max_ff     <= csr_wdata;
            CSR_DEAD_BAND:   dead_band_ff   <= csr_wdata;
            CSR_INVERT_AXIS: invert_axis_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic                    req_accept;
   logic [1:0]              front_busy;
   logic                    q_push;
   job_ctl_type             f_ctl;
   logic [SAMPLE_BITS-1:0]  f_dist;
   logic [SAMPLE_BITS-1:0]  f_span;
   logic [JOB_BITS-1:0]     q_head;
   logic                    q_empty;
   logic                    q_pop;
   logic [COUNT_BITS-1:0]   q_count;
   job_ctl_type             b_ctl;
   logic [SAMPLE_BITS-1:0]  b_dist;
   logic [SAMPLE_BITS-1:0]  b_span;

   // Take a beat only if the queue can hold it along with everything in classify
   assign req_stall  = (int'(q_count) + int'(front_busy)) >= QUEUE_DEPTH;
   assign req_accept = req_valid && !req_stall;

   jads_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .sample      (req_raw_sample),
      .cal_min     (cal_min_ff),
      .cal_center  (cal_center_ff),
      .cal_max     (cal_max_ff),
      .dead_band   (dead_band_ff),
      .invert_axis (invert_axis_ff),
      .busy_count  (front_busy),
      .push        (q_push),
      .push_ctl    (f_ctl),
      .push_dist   (f_dist),
      .push_span   (f_span)
   );

   jads_queue #(
      .WIDTH (JOB_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({f_ctl, f_dist, f_span}),
      .pop       (q_pop),
      .pop_data  (q_head),
      .empty     (q_empty),
      .count     (q_count)
   );

   assign b_ctl  = job_ctl_type'(q_head[JOB_BITS-1:2*SAMPLE_BITS]);
   assign b_dist = q_head[2*SAMPLE_BITS-1:SAMPLE_BITS];
   assign b_span = q_head[SAMPLE_BITS-1:0];

   jads_back #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (q_empty),
      .job_ctl   (b_ctl),
      .job_dist  (b_dist),
      .job_span  (b_span),
      .job_pop   (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_value (rsp_axis_value)
   );

   assert property (@(posedge clock) disable iff (reset)
      q_push |-> (int'(q_count) < QUEUE_DEPTH))
      else $error("job queue overflow");

   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("job queue popped while empty");

   assert property (@(posedge clock) disable iff (reset)
      q_push && q_empty |=> !q_empty)
      else $error("pushed job lost from queue");

endmodule
